// ===== rtl/psb_pkg.sv =====
// Shared types and constants for the palette sprite blitter.
// No dependencies.
`timescale 1ns / 1ps

package psb_pkg;

   localparam int PALETTE_DEPTH_DEF  = 1024;
   localparam int MAX_SPRITE_DIM_DEF = 256;

   localparam int ADDR_IN_W = 10;
   localparam int COLOR_W   = 8;
   localparam int INDEX_W   = 8;
   localparam int ORIGIN_W  = 12;
   localparam int DIM_CFG_W = 9;
   localparam int SHIFT_W   = 3;
   localparam int PSIZE_W   = 9;
   localparam int PSEL_W    = 8;
   localparam int POS_W     = 14;
   localparam int BSIZE_W   = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 12;

   localparam logic                 CMD_WRITE = 1'b0;
   localparam logic                 CMD_DRAW  = 1'b1;
   localparam logic [INDEX_W-1:0]   TRANSPARENT_INDEX = 8'hFF;
   localparam logic [SHIFT_W-1:0]   MAX_SHIFT = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_WIDTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_SHIFT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_SIZE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_SELECT = 3'd6;

   typedef enum logic [1:0] {
      BASE_IDLE,
      BASE_SIZE,
      BASE_MUL
   } base_state_type;

endpackage

// ===== rtl/palette_sprite_blitter.sv =====
// Top level of the palette sprite blitter: palette memory, raster counters,
// palette base unit and output register. Depends on psb_pkg.
`timescale 1ns / 1ps

// Takes one item per clock when not stalled and returns a block descriptor
// from the descriptor stage and output register after an opaque pixel is
// accepted; palette writes and transparent pixels give none. The palette is
// one synchronous memory with a registered read, so a palette write is visible
// to any later pixel. The palette base (select times size, reduced by the
// depth) is kept in a register and rebuilt by a shift-and-add loop after a
// write to palette_size or palette_select: input stalls until the loop ends;
// otherwise the rate is one item per cycle, limited only by result-side stall.
module palette_sprite_blitter #(
   parameter int PALETTE_DEPTH  = psb_pkg::PALETTE_DEPTH_DEF,
   parameter int MAX_SPRITE_DIM = psb_pkg::MAX_SPRITE_DIM_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              csr_write,
   input  logic [psb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psb_pkg::CSR_DAT_W-1:0]     csr_data,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [psb_pkg::ADDR_IN_W-1:0]     req_palette_address,
   input  logic [psb_pkg::COLOR_W-1:0]       req_write_red,
   input  logic [psb_pkg::COLOR_W-1:0]       req_write_green,
   input  logic [psb_pkg::COLOR_W-1:0]       req_write_blue,
   input  logic [psb_pkg::INDEX_W-1:0]       req_pixel_index,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [psb_pkg::POS_W-1:0]         rsp_block_x,
   output logic [psb_pkg::POS_W-1:0]         rsp_block_y,
   output logic [psb_pkg::BSIZE_W-1:0]       rsp_block_size,
   output logic [psb_pkg::COLOR_W-1:0]       rsp_pixel_red,
   output logic [psb_pkg::COLOR_W-1:0]       rsp_pixel_green,
   output logic [psb_pkg::COLOR_W-1:0]       rsp_pixel_blue
);

   import psb_pkg::*;

   localparam int AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int VMAX  = 3 * PALETTE_DEPTH + 1023;
   localparam int KMAX  = VMAX / PALETTE_DEPTH;
   localparam int VW    = $clog2(VMAX + 1);
   localparam int CW    = $clog2(MAX_SPRITE_DIM);
   localparam int DW    = $clog2(MAX_SPRITE_DIM + 1);
   localparam int CMPW  = ((DW > DIM_CFG_W) ? DW : DIM_CFG_W) + 1;
   localparam int RGB_W = 3 * COLOR_W;
   localparam int STEPW = $clog2(PSEL_W);

   // value below VMAX reduced by the palette depth
   function automatic logic [AW-1:0] mod_depth(input logic [VW-1:0] v);
      logic [VW-1:0] r;
      r = v;
      for (int k = 1; k <= KMAX; k++) begin
         if (v >= VW'(k * PALETTE_DEPTH)) begin
            r = v - VW'(k * PALETTE_DEPTH);
         end
      end
      return r[AW-1:0];
   endfunction

   function automatic logic [DW-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
      logic [DW-1:0] r;
      if (v == '0) begin
         r = DW'(1);
      end else if (CMPW'(v) > CMPW'(MAX_SPRITE_DIM)) begin
         r = DW'(MAX_SPRITE_DIM);
      end else begin
         r = DW'(v);
      end
      return r;
   endfunction

   // configuration
   logic [ORIGIN_W-1:0]  origin_x_ff, origin_y_ff;
   logic [DIM_CFG_W-1:0] sprite_width_ff, sprite_height_ff;
   logic [SHIFT_W-1:0]   scale_shift_ff;
   logic [PSIZE_W-1:0]   palette_size_ff;
   logic [PSEL_W-1:0]    palette_select_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff       <= '0;
         origin_y_ff       <= '0;
         sprite_width_ff   <= DIM_CFG_W'(1);
         sprite_height_ff  <= DIM_CFG_W'(1);
         scale_shift_ff    <= '0;
         palette_size_ff   <= PSIZE_W'(256);
         palette_select_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ORIGIN_X:       origin_x_ff       <= csr_data[ORIGIN_W-1:0];
            CSR_ORIGIN_Y:       origin_y_ff       <= csr_data[ORIGIN_W-1:0];
            CSR_SPRITE_WIDTH:   sprite_width_ff   <= csr_data[DIM_CFG_W-1:0];
            CSR_SPRITE_HEIGHT:  sprite_height_ff  <= csr_data[DIM_CFG_W-1:0];
            CSR_SCALE_SHIFT:    scale_shift_ff    <= csr_data[SHIFT_W-1:0];
            CSR_PALETTE_SIZE:   palette_size_ff   <= csr_data[PSIZE_W-1:0];
            CSR_PALETTE_SELECT: palette_select_ff <= csr_data[PSEL_W-1:0];
            default: ;
         endcase
      end
   end

   // palette base unit
   base_state_type     state_ff, state_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [AW-1:0]      size_r_ff, size_r_in;
   logic [STEPW-1:0]   step_ff, step_in;
   logic               base_kick;
   logic [VW-1:0]      base_sum;

   assign base_kick = csr_write &&
                      (csr_index == CSR_PALETTE_SIZE || csr_index == CSR_PALETTE_SELECT);
   assign base_sum  = (VW'(base_ff) << 1) +
                      (palette_select_ff[step_ff] ? VW'(size_r_ff) : VW'(0));

   always_comb begin
      state_in  = state_ff;
      base_in   = base_ff;
      size_r_in = size_r_ff;
      step_in   = step_ff;
      if (base_kick) begin
         state_in = BASE_SIZE;
      end else begin
         unique case (state_ff)
            BASE_IDLE: ;
            BASE_SIZE: begin
               size_r_in = mod_depth(VW'(palette_size_ff));
               base_in   = '0;
               step_in   = STEPW'(PSEL_W - 1);
               state_in  = BASE_MUL;
            end
            BASE_MUL: begin
               base_in = mod_depth(base_sum);
               step_in = step_ff - STEPW'(1);
               if (step_ff == '0) begin
                  state_in = BASE_IDLE;
               end
            end
            default: state_in = BASE_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BASE_IDLE;
         base_ff   <= '0;
         size_r_ff <= '0;
         step_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         base_ff   <= base_in;
         size_r_ff <= size_r_in;
         step_ff   <= step_in;
      end
   end

   // handshake
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic move, s1_ready, accept, opaque, transparent, pal_write;

   assign move        = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s1_ready    = !s1_valid_ff || move;
   assign req_stall   = (state_ff != BASE_IDLE) || !s1_ready;
   assign accept      = req_valid && !req_stall;
   assign pal_write   = accept && (req_command == CMD_WRITE);
   assign opaque      = accept && (req_command == CMD_DRAW) &&
                        (req_pixel_index != TRANSPARENT_INDEX);
   assign transparent = accept && (req_command == CMD_DRAW) &&
                        (req_pixel_index == TRANSPARENT_INDEX);

   // raster counters
   logic [CW-1:0]      col_ff, col_in, row_ff, row_in;
   logic [DW-1:0]      width_c, height_c, col_next, row_next;

   assign width_c  = clamp_dim(sprite_width_ff);
   assign height_c = clamp_dim(sprite_height_ff);
   assign col_next = DW'(col_ff) + DW'(1);
   assign row_next = DW'(row_ff) + DW'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (opaque || transparent) begin
         if (col_next >= width_c) begin
            col_in = '0;
            row_in = (row_next >= height_c) ? '0 : row_next[CW-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // palette memory
   logic [RGB_W-1:0] palette_mem [PALETTE_DEPTH];
   logic [RGB_W-1:0] rdata_ff;
   logic [AW-1:0]    waddr, raddr;

   assign waddr = mod_depth(VW'(req_palette_address));
   assign raddr = mod_depth(VW'(base_ff) + VW'(req_pixel_index));

   always_ff @(posedge clock) begin
      if (pal_write) begin
         palette_mem[waddr] <= {req_write_red, req_write_green, req_write_blue};
      end
      if (opaque) begin
         rdata_ff <= palette_mem[raddr];
      end
   end

   // descriptor stage
   logic [SHIFT_W-1:0] shift;
   logic [POS_W-1:0]   s1_x_ff, s1_x_in, s1_y_ff, s1_y_in;
   logic [BSIZE_W-1:0] s1_size_ff, s1_size_in;

   assign shift      = (scale_shift_ff > MAX_SHIFT) ? MAX_SHIFT : scale_shift_ff;
   assign s1_x_in    = POS_W'(origin_x_ff) + (POS_W'(col_ff) << shift);
   assign s1_y_in    = POS_W'(origin_y_ff) + (POS_W'(row_ff) << shift);
   assign s1_size_in = BSIZE_W'(1) << shift;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_ready) begin
         s1_valid_in = opaque;
      end
      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (opaque) begin
         s1_x_ff    <= s1_x_in;
         s1_y_ff    <= s1_y_in;
         s1_size_ff <= s1_size_in;
      end
   end

   // output register
   logic [POS_W-1:0]   out_x_ff, out_y_ff;
   logic [BSIZE_W-1:0] out_size_ff;
   logic [RGB_W-1:0]   out_rgb_ff;

   always_ff @(posedge clock) begin
      if (move) begin
         out_x_ff    <= s1_x_ff;
         out_y_ff    <= s1_y_ff;
         out_size_ff <= s1_size_ff;
         out_rgb_ff  <= rdata_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_block_x     = out_x_ff;
   assign rsp_block_y     = out_y_ff;
   assign rsp_block_size  = out_size_ff;
   assign rsp_pixel_red   = out_rgb_ff[3*COLOR_W-1:2*COLOR_W];
   assign rsp_pixel_green = out_rgb_ff[2*COLOR_W-1:COLOR_W];
   assign rsp_pixel_blue  = out_rgb_ff[COLOR_W-1:0];

endmodule

// ===== verif/palette_sprite_blitter_tb.sv =====
// Testbench for palette_sprite_blitter: drives palette writes and sprite pixels,
// predicts every block descriptor and checks each one field by field.
// Depends on psb_pkg and the palette_sprite_blitter RTL.
`timescale 1ns / 1ps

module palette_sprite_blitter_tb;
   import psb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic                 command;
      logic [ADDR_IN_W-1:0] address;
      logic [COLOR_W-1:0]   red;
      logic [COLOR_W-1:0]   green;
      logic [COLOR_W-1:0]   blue;
      logic [INDEX_W-1:0]   index;
   } pixel_req_type;

   typedef struct packed {
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic [BSIZE_W-1:0] size;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } block_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_command = 1'b0;
   logic [ADDR_IN_W-1:0] req_palette_address = '0;
   logic [COLOR_W-1:0]   req_write_red = '0;
   logic [COLOR_W-1:0]   req_write_green = '0;
   logic [COLOR_W-1:0]   req_write_blue = '0;
   logic [INDEX_W-1:0]   req_pixel_index = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [POS_W-1:0]     rsp_block_x;
   logic [POS_W-1:0]     rsp_block_y;
   logic [BSIZE_W-1:0]   rsp_block_size;
   logic [COLOR_W-1:0]   rsp_pixel_red;
   logic [COLOR_W-1:0]   rsp_pixel_green;
   logic [COLOR_W-1:0]   rsp_pixel_blue;

   palette_sprite_blitter DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_palette_address (req_palette_address),
      .req_write_red       (req_write_red),
      .req_write_green     (req_write_green),
      .req_write_blue      (req_write_blue),
      .req_pixel_index     (req_pixel_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_block_x         (rsp_block_x),
      .rsp_block_y         (rsp_block_y),
      .rsp_block_size      (rsp_block_size),
      .rsp_pixel_red       (rsp_pixel_red),
      .rsp_pixel_green     (rsp_pixel_green),
      .rsp_pixel_blue      (rsp_pixel_blue)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pixel_req_type pending_items[$];
   block_type     blocks_due[$];

   // register shadows, changed only while the block is idle
   logic [ORIGIN_W-1:0]  cfg_origin_x = '0;
   logic [ORIGIN_W-1:0]  cfg_origin_y = '0;
   logic [DIM_CFG_W-1:0] cfg_width = 9'd1;
   logic [DIM_CFG_W-1:0] cfg_height = 9'd1;
   logic [SHIFT_W-1:0]   cfg_shift = '0;
   logic [PSIZE_W-1:0]   cfg_psize = 9'd256;
   logic [PSEL_W-1:0]    cfg_select = '0;

   logic [23:0] palette_shadow [PALETTE_DEPTH_DEF];
   bit          planned [PALETTE_DEPTH_DEF];
   int          col_pos = 0;
   int          row_pos = 0;
   int          send_gap = 0;
   int          hold_left = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   bit          quiet = 1'b0;

   function automatic int clamp_dim(input logic [DIM_CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_SPRITE_DIM_DEF) return MAX_SPRITE_DIM_DEF;
      return int'(v);
   endfunction

   function automatic int palette_addr(input logic [INDEX_W-1:0] idx);
      return (int'(cfg_select) * int'(cfg_psize) + int'(idx)) % PALETTE_DEPTH_DEF;
   endfunction

   task automatic track_item(input pixel_req_type it);
      int        shift;
      block_type b;
      if (it.command == CMD_WRITE) begin
         palette_shadow[it.address] = {it.red, it.green, it.blue};
      end else begin
         if (it.index != TRANSPARENT_INDEX) begin
            shift = (cfg_shift > MAX_SHIFT) ? int'(MAX_SHIFT) : int'(cfg_shift);
            b.x = POS_W'(int'(cfg_origin_x) + (col_pos << shift));
            b.y = POS_W'(int'(cfg_origin_y) + (row_pos << shift));
            b.size = BSIZE_W'(1 << shift);
            {b.red, b.green, b.blue} = palette_shadow[palette_addr(it.index)];
            blocks_due.push_back(b);
         end
         // raster advance; counters past a shrunken limit wrap here
         if (col_pos + 1 >= clamp_dim(cfg_width)) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= clamp_dim(cfg_height)) ? 0 : row_pos + 1;
         end else begin
            col_pos = col_pos + 1;
         end
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // input side
   always @(posedge clock) begin
      pixel_req_type seen;
      pixel_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            seen.command = req_command;
            seen.address = req_palette_address;
            seen.red = req_write_red;
            seen.green = req_write_green;
            seen.blue = req_write_blue;
            seen.index = req_pixel_index;
            track_item(seen);
            send_gap = quiet ? 0 : $urandom_range(0, 3);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               nxt = pending_items.pop_front();
               req_command <= nxt.command;
               req_palette_address <= nxt.address;
               req_write_red <= nxt.red;
               req_write_green <= nxt.green;
               req_write_blue <= nxt.blue;
               req_pixel_index <= nxt.index;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side
   always @(posedge clock) begin
      block_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (blocks_due.size() == 0) begin
               $error("block item with none expected: x %0d y %0d", rsp_block_x, rsp_block_y);
               mismatches++;
            end else begin
               want = blocks_due.pop_front();
               check_field("block_x", int'(want.x), int'(rsp_block_x));
               check_field("block_y", int'(want.y), int'(rsp_block_y));
               check_field("block_size", int'(want.size), int'(rsp_block_size));
               check_field("pixel_red", int'(want.red), int'(rsp_pixel_red));
               check_field("pixel_green", int'(want.green), int'(rsp_pixel_green));
               check_field("pixel_blue", int'(want.blue), int'(rsp_pixel_blue));
            end
            hold_left = quiet ? 0 : $urandom_range(0, 3);
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic queue_write(input logic [ADDR_IN_W-1:0] a, input logic [23:0] rgb);
      pixel_req_type it;
      it.command = CMD_WRITE;
      it.address = a;
      {it.red, it.green, it.blue} = rgb;
      it.index = INDEX_W'($urandom);
      planned[a] = 1'b1;
      pending_items.push_back(it);
   endtask

   // an opaque pixel whose palette entry is not yet loaded gets a write first
   task automatic queue_pixel(input logic [INDEX_W-1:0] idx);
      pixel_req_type it;
      int            a;
      if (idx != TRANSPARENT_INDEX) begin
         a = palette_addr(idx);
         if (!planned[a]) queue_write(ADDR_IN_W'(a), 24'($urandom));
      end
      it.command = CMD_DRAW;
      it.address = ADDR_IN_W'($urandom);
      it.red = COLOR_W'($urandom);
      it.green = COLOR_W'($urandom);
      it.blue = COLOR_W'($urandom);
      it.index = idx;
      pending_items.push_back(it);
   endtask

   // n counts every queued item, palette loads for new entries included
   task automatic queue_random(input int n);
      int r;
      int start;
      start = pending_items.size();
      while (pending_items.size() - start < n) begin
         r = $urandom_range(0, 99);
         if (r < 20) queue_write(ADDR_IN_W'($urandom), 24'($urandom));
         else if (r < 35) queue_pixel(TRANSPARENT_INDEX);
         else queue_pixel(INDEX_W'($urandom_range(0, 254)));
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() > 0 || req_valid || blocks_due.size() > 0);
      // margin before the next layout is written
      repeat (4) @(posedge clock);
   endtask

   task automatic set_layout(input logic [ORIGIN_W-1:0] ox, input logic [ORIGIN_W-1:0] oy,
                             input logic [DIM_CFG_W-1:0] w, input logic [DIM_CFG_W-1:0] h,
                             input logic [SHIFT_W-1:0] sh, input logic [PSIZE_W-1:0] psz,
                             input logic [PSEL_W-1:0] psel);
      csr_write <= 1'b1;
      csr_index <= CSR_ORIGIN_X;
      csr_data <= CSR_DAT_W'(ox);
      @(posedge clock);
      csr_index <= CSR_ORIGIN_Y;
      csr_data <= CSR_DAT_W'(oy);
      @(posedge clock);
      csr_index <= CSR_SPRITE_WIDTH;
      csr_data <= CSR_DAT_W'(w);
      @(posedge clock);
      csr_index <= CSR_SPRITE_HEIGHT;
      csr_data <= CSR_DAT_W'(h);
      @(posedge clock);
      csr_index <= CSR_SCALE_SHIFT;
      csr_data <= CSR_DAT_W'(sh);
      @(posedge clock);
      csr_index <= CSR_PALETTE_SIZE;
      csr_data <= CSR_DAT_W'(psz);
      @(posedge clock);
      csr_index <= CSR_PALETTE_SELECT;
      csr_data <= CSR_DAT_W'(psel);
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_origin_x = ox;
      cfg_origin_y = oy;
      cfg_width = w;
      cfg_height = h;
      cfg_shift = sh;
      cfg_psize = psz;
      cfg_select = psel;
   endtask

   function automatic logic [DIM_CFG_W-1:0] pick_dim();
      if ($urandom_range(0, 3) == 0) return DIM_CFG_W'($urandom_range(0, 511));
      return DIM_CFG_W'($urandom_range(1, 8));
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 1x1 sprite, palette 0 of 256 entries
      queue_write(10'd0, 24'hFFFFFF);
      queue_write(10'd1023, 24'h000000);
      queue_write(10'd254, 24'hA55AC3);
      queue_pixel(8'd0);
      queue_pixel(8'd254);
      queue_pixel(TRANSPARENT_INDEX);
      queue_pixel(8'd0);
      wait_idle();

      // width zero, oversized height, scale above six, palette size zero
      set_layout(12'd4095, 12'd4095, 9'd0, 9'd511, 3'd7, 9'd0, 8'd255);
      queue_pixel(8'd254);
      queue_pixel(TRANSPARENT_INDEX);
      queue_pixel(8'd0);
      queue_pixel(8'd0);
      wait_idle();

      // odd palette size with top select, 2x2 sprite
      set_layout(12'd0, 12'd0, 9'd2, 9'd2, 3'd0, 9'd511, 8'd255);
      queue_pixel(8'd0);
      queue_pixel(8'd254);
      queue_pixel(TRANSPARENT_INDEX);
      queue_pixel(8'd1);
      queue_pixel(8'd128);
      wait_idle();

      for (int p = 0; p < 10; p++) begin
         quiet = (p % 4 == 3);
         case (p)
            0: set_layout(12'd4095, 12'd0, 9'd257, 9'd2, 3'd6, 9'd256, 8'd0);
            1: set_layout(12'd0, 12'd4095, 9'd1, 9'd256, 3'd6, 9'd1, 8'd3);
            2: set_layout(ORIGIN_W'($urandom), ORIGIN_W'($urandom), 9'd256, 9'd256,
                          3'd0, 9'd16, 8'd200);
            default: set_layout(ORIGIN_W'($urandom), ORIGIN_W'($urandom),
                                pick_dim(), pick_dim(),
                                SHIFT_W'($urandom_range(0, 7)), PSIZE_W'($urandom),
                                PSEL_W'($urandom));
         endcase
         queue_random(p < 2 ? 300 : 110);
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/psb_pkg.sv
rtl/palette_sprite_blitter.sv
verif/palette_sprite_blitter_tb.sv
